### hw/rtl/ptp_pkg.sv
package ptp_pkg;

  // One raw byte with its framing flags
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic       has_signature;
  } ptp_in_item_t;

  // One result item
  typedef struct packed {
    logic [3:0]  field_code;
    logic [63:0] value;
    logic        field_last;
    logic        tx_done;
    logic        truncated;
  } ptp_out_item_t;

  // Marker bytes the parser branches on
  typedef enum logic [3:0] {
    ID_OTHER, ID_DTAG, ID_MEMOS, ID_ARR_END, ID_MEMO,
    ID_MTYPE, ID_MDATA, ID_MFMT, ID_OBJ_END
  } ptp_byte_id_e;

  // Classified byte, as queued between front and back
  typedef struct packed {
    ptp_in_item_t raw;
    logic         le192;
    ptp_byte_id_e id;
  } ptp_cls_item_t;

  typedef enum logic [4:0] {
    ST_IDLE      = 5'd0,
    ST_HEAD      = 5'd1,
    ST_SEQ       = 5'd2,
    ST_DTAG_CHK  = 5'd3,
    ST_DTAG      = 5'd4,
    ST_LLS_SKIP  = 5'd5,
    ST_LASTSEQ   = 5'd6,
    ST_AMT       = 5'd7,
    ST_FEE       = 5'd8,
    ST_VL_ID     = 5'd9,
    ST_VL_LEN    = 5'd10,
    ST_VL_DATA   = 5'd11,
    ST_DER_HDR   = 5'd12,
    ST_DER_TLEN  = 5'd13,
    ST_R_TAG     = 5'd14,
    ST_S_TAG     = 5'd15,
    ST_SIG_PAD   = 5'd16,
    ST_AFTER_DST = 5'd17,
    ST_ARRAY     = 5'd18,
    ST_OBJ       = 5'd19,
    ST_DONE      = 5'd20
  } ptp_step_e;

  // Field codes
  localparam logic [3:0] FC_SEQ     = 4'd0;
  localparam logic [3:0] FC_DTAG    = 4'd1;
  localparam logic [3:0] FC_LASTSEQ = 4'd2;
  localparam logic [3:0] FC_AMOUNT  = 4'd3;
  localparam logic [3:0] FC_FEE     = 4'd4;
  localparam logic [3:0] FC_KEY     = 4'd5;
  localparam logic [3:0] FC_SIG_R   = 4'd6;
  localparam logic [3:0] FC_SIG_S   = 4'd7;
  localparam logic [3:0] FC_ACCT    = 4'd8;
  localparam logic [3:0] FC_DEST    = 4'd9;
  localparam logic [3:0] FC_MTYPE   = 4'd10;
  localparam logic [3:0] FC_MDATA   = 4'd11;
  localparam logic [3:0] FC_MFMT    = 4'd12;
  localparam logic [3:0] FC_MEND    = 4'd13;
  localparam logic [3:0] FC_SIGFLD  = 4'd14;
  localparam logic [3:0] FC_NONE    = 4'd15;

  localparam logic [7:0]  BYTE_DTAG    = 8'h2E;
  localparam logic [7:0]  BYTE_MEMOS   = 8'hF9;
  localparam logic [7:0]  BYTE_ARR_END = 8'hF1;
  localparam logic [7:0]  BYTE_MEMO    = 8'hEA;
  localparam logic [7:0]  BYTE_MTYPE   = 8'h7C;
  localparam logic [7:0]  BYTE_MDATA   = 8'h7D;
  localparam logic [7:0]  BYTE_MFMT    = 8'h7E;
  localparam logic [7:0]  BYTE_OBJ_END = 8'hE1;
  localparam logic [7:0]  PFX_ONE_MAX  = 8'd192;
  localparam logic [7:0]  PFX_TWO_MAX  = 8'd240;
  localparam logic [19:0] PFX_THREE_BASE = 20'd12481;

endpackage

### hw/rtl/ptp_front.sv
module ptp_front
  import ptp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  ptp_in_item_t  in_item_i,
  output logic          q_valid_o,
  output ptp_cls_item_t q_item_o,
  input  logic          q_pop_i
);

  ptp_cls_item_t       cls;
  ptp_cls_item_t [1:0] mem_q;
  logic                wr_q, rd_q;
  logic [1:0]          cnt_q;
  logic                do_push, do_pop;

  // Classify the incoming byte
  always_comb begin
    cls.raw   = in_item_i;
    cls.le192 = in_item_i.data_byte <= PFX_ONE_MAX;
    case (in_item_i.data_byte)
      BYTE_DTAG:    cls.id = ID_DTAG;
      BYTE_MEMOS:   cls.id = ID_MEMOS;
      BYTE_ARR_END: cls.id = ID_ARR_END;
      BYTE_MEMO:    cls.id = ID_MEMO;
      BYTE_MTYPE:   cls.id = ID_MTYPE;
      BYTE_MDATA:   cls.id = ID_MDATA;
      BYTE_MFMT:    cls.id = ID_MFMT;
      BYTE_OBJ_END: cls.id = ID_OBJ_END;
      default:      cls.id = ID_OTHER;
    endcase
  end

  assign full_o    = cnt_q[1];
  assign q_valid_o = cnt_q != 2'd0;
  assign q_item_o  = mem_q[rd_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = q_pop_i && q_valid_o;

  // Two-entry queue toward the parser
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= cls;
  end

endmodule

### hw/rtl/ptp_back.sv
module ptp_back
  import ptp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  ptp_cls_item_t q_item_i,
  output logic          q_pop_o,
  input  logic          res_full_i,
  output logic          res_push_o,
  output ptp_out_item_t res_item_o
);

  typedef struct packed {
    ptp_step_e   step;
    logic [19:0] bl;
    logic [63:0] acc;
    logic [7:0]  pf;
    logic [7:0]  ps;
  } core_t;

  typedef struct packed {
    logic        done;
    logic [19:0] len;
    logic [19:0] bl;
    logic [7:0]  pf;
    logic [7:0]  ps;
  } pfx_t;

  function automatic core_t enter(ptp_step_e step, logic [3:0] code);
    core_t c;
    c.step = step;
    c.acc  = {60'd0, code};
    c.bl   = '0;
    c.pf   = '0;
    c.ps   = '0;
    return c;
  endfunction

  function automatic core_t enter_fixed(ptp_step_e step, logic [19:0] cnt);
    core_t c;
    c    = enter(step, FC_SEQ);
    c.bl = cnt;
    return c;
  endfunction

  // One step of the 1-to-3-byte length prefix
  function automatic pfx_t feed(core_t c, ptp_cls_item_t it);
    pfx_t p;
    logic [19:0] b20;
    b20    = {12'd0, it.raw.data_byte};
    p.done = 1'b0;
    p.len  = '0;
    p.bl   = c.bl;
    p.pf   = c.pf;
    p.ps   = c.ps;
    if (c.pf <= PFX_ONE_MAX) begin
      if (it.le192) begin
        p.done = 1'b1;
        p.len  = b20;
      end else begin
        p.pf = it.raw.data_byte;
      end
    end else if (c.pf <= PFX_TWO_MAX) begin
      p.done = 1'b1;
      p.len  = 20'd193 + (({12'd0, c.pf} - 20'd193) << 8) + b20;
      p.pf   = '0;
    end else if (c.bl == 20'd0) begin
      p.ps = it.raw.data_byte;
      p.bl = 20'd1;
    end else begin
      p.done = 1'b1;
      p.len  = PFX_THREE_BASE + (({12'd0, c.pf} - 20'd241) << 16)
             + {4'd0, c.ps, 8'd0} + b20;
      p.pf   = '0;
      p.ps   = '0;
      p.bl   = '0;
    end
    return p;
  endfunction

  core_t       cs_q, cs_d;
  logic [19:0] sig_q, sig_d;
  logic        sm_q, sm_d;
  logic        take, emit, flast, drop, in_sig, trunc;
  logic [3:0]  code, fc;
  logic [63:0] val;
  pfx_t        pfx;

  assign take    = q_valid_i && !res_full_i;
  assign q_pop_o = take;
  assign fc      = cs_q.acc[3:0];

  // Parse step
  always_comb begin
    cs_d   = cs_q;
    sig_d  = sig_q;
    sm_d   = sm_q;
    emit   = 1'b0;
    flast  = 1'b0;
    drop   = 1'b0;
    trunc  = 1'b0;
    code   = FC_NONE;
    val    = '0;
    in_sig = 1'b0;
    pfx    = feed(cs_q, q_item_i);
    if (take) begin
      if (q_item_i.raw.first_byte) begin
        sm_d  = q_item_i.raw.has_signature;
        sig_d = '0;
        cs_d  = enter_fixed(ST_HEAD, 20'd8);
      end else begin
        in_sig = (cs_q.step inside {[ST_DER_HDR:ST_SIG_PAD]}) ||
                 ((cs_q.step == ST_VL_LEN || cs_q.step == ST_VL_DATA) &&
                  (cs_q.acc == 64'd6 || cs_q.acc == 64'd7));
        case (cs_q.step)
          ST_HEAD, ST_LLS_SKIP: begin
            cs_d.bl = cs_q.bl - 20'd1;
            if (cs_d.bl == 20'd0)
              cs_d = enter_fixed((cs_q.step == ST_HEAD) ? ST_SEQ : ST_LASTSEQ, 20'd4);
          end
          ST_SEQ, ST_DTAG, ST_LASTSEQ: begin
            cs_d.acc = {32'd0, cs_q.acc[23:0], q_item_i.raw.data_byte};
            cs_d.bl  = cs_q.bl - 20'd1;
            if (cs_d.bl == 20'd0) begin
              emit  = 1'b1;
              flast = 1'b1;
              val   = cs_d.acc;
              if (cs_q.step == ST_SEQ) begin
                code = FC_SEQ;
                cs_d = enter(ST_DTAG_CHK, FC_SEQ);
              end else if (cs_q.step == ST_DTAG) begin
                code = FC_DTAG;
                cs_d = enter_fixed(ST_LLS_SKIP, 20'd2);
              end else begin
                code = FC_LASTSEQ;
                cs_d = enter_fixed(ST_AMT, 20'd9);
              end
            end
          end
          ST_DTAG_CHK: begin
            if (q_item_i.id == ID_DTAG) cs_d = enter_fixed(ST_DTAG, 20'd4);
            else                        cs_d = enter_fixed(ST_LLS_SKIP, 20'd1);
          end
          ST_AMT, ST_FEE: begin
            if (cs_q.bl != 20'd9) cs_d.acc = {cs_q.acc[55:0], q_item_i.raw.data_byte};
            cs_d.bl = cs_q.bl - 20'd1;
            if (cs_d.bl == 20'd0) begin
              emit  = 1'b1;
              flast = 1'b1;
              // subtract 2^62: only the top two bits change
              val   = {cs_d.acc[63:62] - 2'd1, cs_d.acc[61:0]};
              if (cs_q.step == ST_AMT) begin
                code = FC_AMOUNT;
                cs_d = enter_fixed(ST_FEE, 20'd9);
              end else begin
                code = FC_FEE;
                cs_d = enter(ST_VL_ID, FC_KEY);
              end
            end
          end
          ST_VL_ID: cs_d = enter(ST_VL_LEN, fc);
          ST_VL_LEN: begin
            cs_d.pf = pfx.pf;
            cs_d.ps = pfx.ps;
            cs_d.bl = pfx.bl;
            if (pfx.done) begin
              if (cs_q.acc == {60'd0, FC_SIGFLD}) begin
                sig_d = pfx.len;
                if (pfx.len == 20'd0) cs_d = enter(ST_VL_ID, FC_ACCT);
                else                  cs_d = enter(ST_DER_HDR, FC_SEQ);
              end else if (pfx.len == 20'd0) begin
                case (fc)
                  FC_KEY:   cs_d = enter(ST_VL_ID, sm_q ? FC_SIGFLD : FC_ACCT);
                  FC_SIG_R: cs_d = enter(ST_S_TAG, FC_SEQ);
                  FC_SIG_S: cs_d = enter(ST_SIG_PAD, FC_SEQ);
                  FC_ACCT:  cs_d = enter(ST_VL_ID, FC_DEST);
                  FC_DEST:  cs_d = enter(ST_AFTER_DST, FC_SEQ);
                  default:  cs_d = enter(ST_OBJ, FC_SEQ);
                endcase
              end else begin
                cs_d.step = ST_VL_DATA;
                cs_d.bl   = pfx.len;
              end
            end
          end
          ST_VL_DATA: begin
            emit    = 1'b1;
            code    = fc;
            val     = {56'd0, q_item_i.raw.data_byte};
            cs_d.bl = cs_q.bl - 20'd1;
            if (cs_d.bl == 20'd0) begin
              flast = 1'b1;
              case (fc)
                FC_KEY:   cs_d = enter(ST_VL_ID, sm_q ? FC_SIGFLD : FC_ACCT);
                FC_SIG_R: cs_d = enter(ST_S_TAG, FC_SEQ);
                FC_SIG_S: cs_d = enter(ST_SIG_PAD, FC_SEQ);
                FC_ACCT:  cs_d = enter(ST_VL_ID, FC_DEST);
                FC_DEST:  cs_d = enter(ST_AFTER_DST, FC_SEQ);
                default:  cs_d = enter(ST_OBJ, FC_SEQ);
              endcase
            end
          end
          ST_DER_HDR: cs_d = enter(ST_DER_TLEN, FC_SEQ);
          ST_DER_TLEN: begin
            cs_d.pf = pfx.pf;
            cs_d.ps = pfx.ps;
            cs_d.bl = pfx.bl;
            if (pfx.done) cs_d = enter(ST_R_TAG, FC_SEQ);
          end
          ST_R_TAG: cs_d = enter(ST_VL_LEN, FC_SIG_R);
          ST_S_TAG: cs_d = enter(ST_VL_LEN, FC_SIG_S);
          ST_AFTER_DST: begin
            if (q_item_i.id == ID_MEMOS) cs_d = enter(ST_ARRAY, FC_SEQ);
            else                         cs_d = enter(ST_DONE, FC_SEQ);
          end
          ST_ARRAY: begin
            if (q_item_i.id == ID_ARR_END)   cs_d = enter(ST_DONE, FC_SEQ);
            else if (q_item_i.id == ID_MEMO) cs_d = enter(ST_OBJ, FC_SEQ);
          end
          ST_OBJ: begin
            case (q_item_i.id)
              ID_MTYPE: cs_d = enter(ST_VL_LEN, FC_MTYPE);
              ID_MDATA: cs_d = enter(ST_VL_LEN, FC_MDATA);
              ID_MFMT:  cs_d = enter(ST_VL_LEN, FC_MFMT);
              ID_OBJ_END: begin
                emit  = 1'b1;
                flast = 1'b1;
                code  = FC_MEND;
                cs_d  = enter(ST_ARRAY, FC_SEQ);
              end
              default: ;
            endcase
          end
          ST_SIG_PAD, ST_DONE: ;
          default: begin
            // idle: bytes outside a transaction are dropped
            drop = 1'b1;
            cs_d = enter(ST_IDLE, FC_SEQ);
          end
        endcase
        // signature field byte budget
        if (!drop && in_sig && sig_q != 20'd0) begin
          sig_d = sig_q - 20'd1;
          if (sig_d == 20'd0) begin
            cs_d = enter(ST_VL_ID, FC_ACCT);
            if (emit) flast = 1'b1;
          end
        end
      end
      if (!drop && q_item_i.raw.last_byte) begin
        trunc = !(cs_d.step == ST_AFTER_DST || cs_d.step == ST_DONE);
        cs_d  = enter(ST_IDLE, FC_SEQ);
        sig_d = '0;
      end
    end
  end

  assign res_push_o            = take && !drop && (emit || q_item_i.raw.last_byte);
  assign res_item_o.field_code = emit ? code : FC_NONE;
  assign res_item_o.value      = emit ? val : 64'd0;
  assign res_item_o.field_last = emit && flast;
  assign res_item_o.tx_done    = q_item_i.raw.last_byte;
  assign res_item_o.truncated  = trunc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q  <= enter(ST_IDLE, FC_SEQ);
      sig_q <= '0;
      sm_q  <= 1'b0;
    end else begin
      cs_q  <= cs_d;
      sig_q <= sig_d;
      sm_q  <= sm_d;
    end
  end

endmodule

### hw/rtl/ptp_out_fifo.sv
module ptp_out_fifo
  import ptp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ptp_out_item_t item_i,
  output logic          full_o,
  output logic          empty_o,
  input  logic          pop_i,
  output ptp_out_item_t item_o
);

  ptp_out_item_t [1:0] mem_q;
  logic                wr_q, rd_q;
  logic [1:0]          cnt_q;
  logic                do_push, do_pop;

  assign full_o  = cnt_q[1];
  assign empty_o = cnt_q == 2'd0;
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Two-entry result queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= item_i;
  end

endmodule

### hw/rtl/payment_tx_byte_parser.sv
// Payment transaction byte parser.
// Input channel: push_i / full_o carry one transaction byte per item, with
// first_byte (restarts the parse, samples has_signature) and last_byte.
// Result channel: empty_o / pop_i; the oldest result sits on out_item_o
// while empty_o is low. Each byte yields zero or one result: fixed numeric
// fields as one value, variable fields one payload byte per result, a memo-end
// marker result, and a closing result (tx_done) on the last byte.
// Throughput: one byte per cycle while the receiver keeps up. A byte is
// classified and queued in a two-entry input queue, parsed one per cycle
// by the back end while the output queue has room, and its result is
// registered into a two-entry output queue, from which it can be popped.
// When the receiver stalls, the output queue fills, the parser stops taking
// bytes, and full_o rises once the input queue holds two bytes; nothing is
// lost. Reset empties both queues and leaves the parser idle, waiting for a
// byte flagged first_byte.
module payment_tx_byte_parser
  import ptp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  ptp_in_item_t  in_item_i,
  output logic          empty_o,
  input  logic          pop_i,
  output ptp_out_item_t out_item_o
);

  logic          q_valid, q_pop, res_full, res_push;
  ptp_cls_item_t q_item;
  ptp_out_item_t res_item;

  ptp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_i),
    .full_o    (full_o),
    .in_item_i (in_item_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  ptp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_item_o (res_item)
  );

  ptp_out_fifo u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .item_i  (res_item),
    .full_o  (res_full),
    .empty_o (empty_o),
    .pop_i   (pop_i),
    .item_o  (out_item_o)
  );

endmodule
